// ===== rtl/ppd_pkg.sv =====
// Shared types, constants and helpers for the pump pressure PID drive.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ppd_pkg;

    // Widest feedback count and widest pump duty the internal datapath carries.
    localparam int FB_MAX_W   = 32;
    localparam int DUTY_MAX_W = 16;

    typedef logic signed [39:0] t_s40;
    typedef logic signed [17:0] t_s18;

    localparam t_s40 S40_MAX = {1'b0, {39{1'b1}}};
    localparam t_s40 S40_MIN = {1'b1, 39'b0};

    localparam int unsigned PUSH_CAP      = 400;
    localparam int unsigned GAIN_DIVISOR  = 5;
    localparam int unsigned BLOWOFF_SCALE = 5;
    // Weighted sum at or above which the correction reaches the push cap.
    localparam int unsigned PUSH_CAP_SUM  = PUSH_CAP * GAIN_DIVISOR;
    // Reciprocal of 5 in 14 fractional bits; exact for sums below PUSH_CAP_SUM.
    localparam int unsigned DIV5_RECIP    = 3277;
    localparam int unsigned DIV5_SHIFT    = 14;

    localparam logic [7:0]  KP_RST     = 8'd10;
    localparam logic [15:0] WINDUP_RST = 16'd20000;

    typedef enum logic [1:0] {
        ACT_PUSH    = 2'd0,
        ACT_BLOWOFF = 2'd1,
        ACT_WAIT    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CFG_INITIAL_READING = 3'd0,
        CFG_INCREMENT       = 3'd1,
        CFG_TOTAL_TARGET    = 3'd2,
        CFG_KP              = 3'd3,
        CFG_KI              = 3'd4,
        CFG_KD              = 3'd5,
        CFG_WINDUP          = 3'd6,
        CFG_PWM_FLOOR       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] kp;
        logic [7:0] ki;
        logic [7:0] kd;
    } t_gains;

    typedef struct packed {
        t_s40 err;
        t_s40 deriv;
        t_s18 integ;
        logic done;
    } t_trk_res;

    typedef struct packed {
        t_s40 sum;
        logic done;
    } t_sum_res;

    typedef struct packed {
        t_action               action;
        logic [DUTY_MAX_W-1:0] duty;
        logic                  valve;
        logic                  done;
    } t_act_res;

    // Saturate a wide signed value to the 40-bit signed range.
    function automatic t_s40 sat40(input logic signed [51:0] v);
        if (v > 52'(S40_MAX)) begin
            return S40_MAX;
        end else if (v < 52'(S40_MIN)) begin
            return S40_MIN;
        end else begin
            return v[39:0];
        end
    endfunction

endpackage

// ===== rtl/ppd_track.sv =====
// Target tracking stage: running target, error, derivative, clamped integral
// and the finish latch. Depends on ppd_pkg.
`timescale 1ns / 1ps

module ppd_track (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_tgt_load,
    input  logic [23:0]                   i_tgt_value,
    input  logic [ppd_pkg::FB_MAX_W-1:0]  i_feedback,
    input  logic [15:0]                   i_increment,
    input  logic [23:0]                   i_total_target,
    input  logic [15:0]                   i_windup,
    output ppd_pkg::t_trk_res             o_res
);
    import ppd_pkg::*;

    t_s40     r_target;
    t_s40     r_last_err;
    t_s18     r_integ;
    logic     r_finished;
    t_trk_res r_res;

    logic signed [51:0] fb_w;
    logic signed [51:0] inc_w;
    logic signed [41:0] integ_sum;
    logic signed [41:0] integ_lim;
    t_s40               n_target;
    t_s40               err;
    t_s40               deriv;
    t_s18               n_integ;
    logic               finish_hit;

    always_comb begin
        fb_w       = 52'(i_feedback);
        inc_w      = 52'(i_increment);
        finish_hit = r_finished || (i_feedback <= FB_MAX_W'(i_total_target));
        n_target   = sat40(52'(r_target) - inc_w);
        err        = sat40(fb_w - 52'(n_target));
        deriv      = sat40(52'(err) - 52'(r_last_err));
        integ_lim  = 42'(i_windup);
        integ_sum  = 42'(r_integ) + 42'(err);
        if (integ_sum > integ_lim) begin
            n_integ = 18'(integ_lim);
        end else if (integ_sum < -integ_lim) begin
            n_integ = 18'(-integ_lim);
        end else begin
            n_integ = 18'(integ_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= '0;
            r_last_err <= '0;
            r_integ    <= '0;
            r_finished <= 1'b0;
        end else if (i_tgt_load) begin
            r_target <= 40'(i_tgt_value);
        end else if (i_load) begin
            if (finish_hit) begin
                r_finished <= 1'b1;
            end else begin
                r_target   <= n_target;
                r_last_err <= err;
                r_integ    <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res.err   <= err;
            r_res.deriv <= deriv;
            r_res.integ <= n_integ;
            r_res.done  <= finish_hit;
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/ppd_gain.sv =====
// Gain stages: three registered products, then a saturated weighted sum.
// Depends on ppd_pkg.
`timescale 1ns / 1ps

module ppd_gain (
    input  logic              i_clk,
    input  logic              i_load_mul,
    input  logic              i_load_sum,
    input  ppd_pkg::t_trk_res i_res,
    input  ppd_pkg::t_gains   i_gains,
    output ppd_pkg::t_sum_res o_sum
);
    import ppd_pkg::*;

    logic signed [48:0] r_p_kp;
    logic signed [48:0] r_p_kd;
    logic signed [26:0] r_p_ki;
    logic               r_done;
    t_sum_res           r_sum;

    logic signed [48:0] p_kp;
    logic signed [48:0] p_kd;
    logic signed [26:0] p_ki;
    logic signed [51:0] sum_w;

    always_comb begin
        p_kp  = 49'($signed({1'b0, i_gains.kp})) * 49'(i_res.err);
        p_kd  = 49'($signed({1'b0, i_gains.kd})) * 49'(i_res.deriv);
        p_ki  = 27'($signed({1'b0, i_gains.ki})) * 27'(i_res.integ);
        sum_w = 52'(r_p_kp) + 52'(r_p_kd) + 52'(r_p_ki);
    end

    always_ff @(posedge i_clk) begin
        if (i_load_mul) begin
            r_p_kp <= p_kp;
            r_p_kd <= p_kd;
            r_p_ki <= p_ki;
            r_done <= i_res.done;
        end
        if (i_load_sum) begin
            r_sum.sum  <= sat40(sum_w);
            r_sum.done <= r_done;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== rtl/ppd_act.sv =====
// Action stage: picks push, blowoff, wait or done from the weighted sum and
// keeps the blowoff latch. Depends on ppd_pkg.
`timescale 1ns / 1ps

module ppd_act (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ppd_pkg::t_sum_res i_sum,
    input  logic [15:0]       i_increment,
    input  logic [9:0]        i_pwm_floor,
    output ppd_pkg::t_act_res o_res
);
    import ppd_pkg::*;

    localparam t_s40 PUSH_MIN = t_s40'(GAIN_DIVISOR);
    localparam t_s40 CAP_MIN  = t_s40'(PUSH_CAP_SUM);

    logic     r_latched;
    t_act_res r_res;

    logic                  n_latched;
    t_act_res              n_res;
    logic [20:0]           thr;
    logic signed [41:0]    blow_w;
    logic                  is_push;
    logic                  is_blow;
    logic [23:0]           quo_prod;
    logic [9:0]            quo;
    logic [DUTY_MAX_W-1:0] duty_push;
    logic [DUTY_MAX_W-1:0] duty_floor;

    // The correction is the sum divided by 5 toward zero. Its tests are made
    // on the sum itself: positive means sum >= 5, and below -5*increment
    // means sum <= -(25*increment + 5).
    always_comb begin
        thr        = 21'(i_increment) * 21'(BLOWOFF_SCALE * GAIN_DIVISOR)
                     + 21'(GAIN_DIVISOR);
        blow_w     = 42'(i_sum.sum) + 42'(thr);
        is_blow    = blow_w <= 0;
        is_push    = i_sum.sum >= PUSH_MIN;
        quo_prod   = 24'(i_sum.sum[10:0]) * 24'(DIV5_RECIP);
        quo        = 10'(quo_prod >> DIV5_SHIFT);
        duty_push  = (i_sum.sum >= CAP_MIN) ? DUTY_MAX_W'(PUSH_CAP) : DUTY_MAX_W'(quo);
        duty_floor = DUTY_MAX_W'(i_pwm_floor);

        n_latched   = r_latched;
        n_res.valve = 1'b1;
        n_res.done  = 1'b0;
        priority if (i_sum.done) begin
            n_res.action = ACT_NONE;
            n_res.duty   = duty_floor;
            n_res.valve  = 1'b0;
            n_res.done   = 1'b1;
        end else if (is_push) begin
            n_res.action = ACT_PUSH;
            n_res.duty   = duty_push;
            n_latched    = 1'b0;
        end else if (is_blow) begin
            if (!r_latched) begin
                n_res.action = ACT_BLOWOFF;
                n_res.duty   = duty_floor;
                n_latched    = 1'b1;
            end else begin
                n_res.action = ACT_NONE;
                n_res.duty   = '0;
            end
        end else begin
            n_res.action = ACT_WAIT;
            n_res.duty   = duty_floor;
            n_latched    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched <= 1'b0;
        end else if (i_load) begin
            r_latched <= n_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/pump_pressure_pid_drive.sv =====
// Top level of the pump pressure PID drive: stream ports, configuration
// registers and pipeline flow control. Depends on ppd_pkg, ppd_track,
// ppd_gain and ppd_act.
`timescale 1ns / 1ps

// Usage
// Each transfer on the s_axis channel carries one feedback interval count.
// For every such transfer the block returns exactly one result transfer on
// m_axis: the action in tuser and the pump duty, valve level and done flag
// in tdata.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index,
// i_cfg_data) writes one register per transfer and is always ready. Writing
// the initial reading also reloads the running target. Registers should be
// written only while no item is in flight.
// Pipeline: five stages (input, tracking, products, weighted sum, output).
// A result is offered from the output stage register. One item is accepted
// every cycle while m_axis_tready keeps the pipeline moving. The tracking
// stage closes the loop through the running target, integral and last
// error from one item to the next.
// Reset empties the pipeline, clears the running target, integral, last
// error, blowoff latch and finish flag, and returns the gains and limits to
// their defaults.
// When the receiver stalls, items collect in empty stages; s_axis_tready
// falls only once all five stages hold an item.
module pump_pressure_pid_drive #(
    parameter int  FEEDBACK_WIDTH = 24,
    parameter int  DUTY_WIDTH     = 10,
    localparam int IN_TDATA_W     = ((FEEDBACK_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W    = ((DUTY_WIDTH + 2 + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream. tdata: feedback.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Result stream. tdata: pump_duty, valve_high, done_res. tuser: action.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]             m_axis_tuser,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic [23:0]            i_cfg_data
);
    import ppd_pkg::*;

    localparam int NSTG   = 5;
    localparam int ST_IN  = 0;
    localparam int ST_TRK = 1;
    localparam int ST_MUL = 2;
    localparam int ST_SUM = 3;
    localparam int ST_OUT = 4;

    // Configuration registers. The initial reading is not kept: its only use
    // is to load the running target when it is written.
    logic [15:0] r_increment;
    logic [23:0] r_total_target;
    logic [7:0]  r_kp;
    logic [7:0]  r_ki;
    logic [7:0]  r_kd;
    logic [15:0] r_windup;
    logic [9:0]  r_pwm_floor;

    logic        cfg_wr;
    logic        tgt_load;
    t_gains      gains;

    // Pipeline occupancy and flow control.
    logic [NSTG-1:0]           r_vld;
    logic [NSTG-1:0]           n_vld;
    logic [NSTG-1:0]           rdy;
    logic [NSTG-1:0]           ld;
    logic [FEEDBACK_WIDTH-1:0] r_feedback;

    t_trk_res trk_res;
    t_sum_res sum_res;
    t_act_res act_res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign tgt_load    = cfg_wr && (t_cfg_idx'(i_cfg_index) == CFG_INITIAL_READING);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_increment    <= '0;
            r_total_target <= '0;
            r_kp           <= KP_RST;
            r_ki           <= '0;
            r_kd           <= '0;
            r_windup       <= WINDUP_RST;
            r_pwm_floor    <= '0;
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_INITIAL_READING: begin
                end
                CFG_INCREMENT:    r_increment    <= i_cfg_data[15:0];
                CFG_TOTAL_TARGET: r_total_target <= i_cfg_data;
                CFG_KP:           r_kp           <= i_cfg_data[7:0];
                CFG_KI:           r_ki           <= i_cfg_data[7:0];
                CFG_KD:           r_kd           <= i_cfg_data[7:0];
                CFG_WINDUP:       r_windup       <= i_cfg_data[15:0];
                CFG_PWM_FLOOR:    r_pwm_floor    <= i_cfg_data[9:0];
            endcase
        end
    end

    assign gains.kp = r_kp;
    assign gains.ki = r_ki;
    assign gains.kd = r_kd;

    // A stage takes a new item when it is empty or its item moves on.
    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        ld[0]    = s_axis_tvalid && rdy[0];
        n_vld[0] = rdy[0] ? s_axis_tvalid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            ld[k]    = r_vld[k-1] && rdy[k];
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[ST_IN]) begin
            r_feedback <= s_axis_tdata[FEEDBACK_WIDTH-1:0];
        end
    end

    ppd_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (ld[ST_TRK]),
        .i_tgt_load     (tgt_load),
        .i_tgt_value    (i_cfg_data),
        .i_feedback     (FB_MAX_W'(r_feedback)),
        .i_increment    (r_increment),
        .i_total_target (r_total_target),
        .i_windup       (r_windup),
        .o_res          (trk_res)
    );

    ppd_gain u_gain (
        .i_clk      (i_clk),
        .i_load_mul (ld[ST_MUL]),
        .i_load_sum (ld[ST_SUM]),
        .i_res      (trk_res),
        .i_gains    (gains),
        .o_sum      (sum_res)
    );

    ppd_act u_act (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (ld[ST_OUT]),
        .i_sum       (sum_res),
        .i_increment (r_increment),
        .i_pwm_floor (r_pwm_floor),
        .o_res       (act_res)
    );

    assign s_axis_tready = rdy[ST_IN];
    assign m_axis_tvalid = r_vld[ST_OUT];
    assign m_axis_tdata  = OUT_TDATA_W'({act_res.done, act_res.valve,
                                         act_res.duty[DUTY_WIDTH-1:0]});
    assign m_axis_tuser  = act_res.action;

`ifndef NO_ASSERTIONS
    // A finished result always reports no action with the valve low.
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[DUTY_WIDTH+1]) |->
            (m_axis_tuser == ACT_NONE && !m_axis_tdata[DUTY_WIDTH]))
        else $error("done result with wrong action or valve level");

    // A push drives a duty between one and the push cap.
    a_push_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ACT_PUSH) |->
            (m_axis_tdata[DUTY_WIDTH-1:0] <= DUTY_WIDTH'(PUSH_CAP) &&
             m_axis_tdata[DUTY_WIDTH-1:0] != '0))
        else $error("push duty out of range");

    // The input side stalls only when every stage is full and the output waits.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld && !m_axis_tready))
        else $error("input stalled while the pipeline had room");
`endif

endmodule
